// ----- src/aabb_contact_side_finder_macros.svh -----
// assertion macros for the contact side finder
// no dependencies; included by files that carry concurrent assertions
`ifndef AABB_CONTACT_SIDE_FINDER_MACROS_SVH
`define AABB_CONTACT_SIDE_FINDER_MACROS_SVH
`ifndef ASSERT_OFF
// assertion on an explicit clock and active-low reset
`define ACSF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// assertion on the block clock and reset
`define ACSF_ASSERT(lbl, prop, msg) \
  `ACSF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ACSF_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ACSF_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- src/acsf_pkg.sv -----
// types and constants of the contact side finder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package acsf_pkg;

  // coordinate and distance widths
  localparam int CoordBits = 16;
  localparam int DistBits  = CoordBits + 1;

  // configuration register file
  localparam int NumRegs    = 8;
  localparam int RegIdxBits = 3;
  localparam int CfgIdxBits = 4;

  localparam logic [RegIdxBits-1:0] RegMoverLeft       = 3'd0;
  localparam logic [RegIdxBits-1:0] RegMoverRight      = 3'd1;
  localparam logic [RegIdxBits-1:0] RegMoverTop        = 3'd2;
  localparam logic [RegIdxBits-1:0] RegMoverBottom     = 3'd3;
  localparam logic [RegIdxBits-1:0] RegMoverPrevLeft   = 3'd4;
  localparam logic [RegIdxBits-1:0] RegMoverPrevRight  = 3'd5;
  localparam logic [RegIdxBits-1:0] RegMoverPrevTop    = 3'd6;
  localparam logic [RegIdxBits-1:0] RegMoverPrevBottom = 3'd7;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DistBits-1:0]  dist_t;
  typedef logic [DistBits-1:0]         mag_t;

  typedef enum logic [2:0] {
    SideNone   = 3'd0,
    SideLeft   = 3'd1,
    SideRight  = 3'd2,
    SideTop    = 3'd3,
    SideBottom = 3'd4
  } side_e;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t top;
    coord_t bottom;
  } box_t;

  typedef struct packed {
    box_t cur;
    box_t prev;
  } mover_cfg_t;

  typedef struct packed {
    coord_t obs_left;
    coord_t obs_right;
    coord_t obs_top;
    coord_t obs_bottom;
    coord_t obs_prev_left;
    coord_t obs_prev_right;
    coord_t obs_prev_top;
    coord_t obs_prev_bottom;
    logic   last_item;
  } obs_item_t;

  typedef struct packed {
    side_e  hit_side;
    coord_t hit_left;
    coord_t hit_right;
    coord_t hit_top;
    coord_t hit_bottom;
  } hit_item_t;

  // sign-extend a coordinate to distance width
  function automatic dist_t ext(coord_t v);
    return dist_t'(v);
  endfunction

  // magnitude of a distance
  function automatic mag_t mag(dist_t d);
    return d[DistBits-1] ? mag_t'(-d) : mag_t'(d);
  endfunction

endpackage

// ----- src/acsf_cfg_regs.sv -----
// register file holding the moving box's current and previous edges
// depends on acsf_pkg
`timescale 1ns / 1ps

module acsf_cfg_regs import acsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CfgIdxBits-1:0] wr_index_i,
  input  coord_t                wr_data_i,
  output mover_cfg_t            mover_o
);

  coord_t regs_q [NumRegs];

  // write one register; indexes beyond the file are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
      end
    end else if (wr_en_i && (wr_index_i < CfgIdxBits'(NumRegs))) begin
      regs_q[wr_index_i[RegIdxBits-1:0]] <= wr_data_i;
    end
  end

  // fixed mapping onto the mover box
  always_comb begin
    mover_o.cur.left     = regs_q[RegMoverLeft];
    mover_o.cur.right    = regs_q[RegMoverRight];
    mover_o.cur.top      = regs_q[RegMoverTop];
    mover_o.cur.bottom   = regs_q[RegMoverBottom];
    mover_o.prev.left    = regs_q[RegMoverPrevLeft];
    mover_o.prev.right   = regs_q[RegMoverPrevRight];
    mover_o.prev.top     = regs_q[RegMoverPrevTop];
    mover_o.prev.bottom  = regs_q[RegMoverPrevBottom];
  end

endmodule

// ----- src/acsf_side_calc.sv -----
// overlap test and side-of-approach choice for one obstacle
// depends on acsf_pkg
`timescale 1ns / 1ps

module acsf_side_calc import acsf_pkg::*; (
  input  mover_cfg_t mover_i,
  input  obs_item_t  obs_i,
  output side_e      side_o
);

  coord_t a_l, a_r, a_t, a_b, ap_l, ap_r, ap_t, ap_b;
  coord_t b_l, b_r, b_t, b_b, bp_l, bp_r, bp_t, bp_b;
  logic   overlap;
  dist_t  hd, vd;
  side_e  hs, vs, pick;

  always_comb begin
    a_l  = mover_i.cur.left;
    a_r  = mover_i.cur.right;
    a_t  = mover_i.cur.top;
    a_b  = mover_i.cur.bottom;
    ap_l = mover_i.prev.left;
    ap_r = mover_i.prev.right;
    ap_t = mover_i.prev.top;
    ap_b = mover_i.prev.bottom;
    b_l  = obs_i.obs_left;
    b_r  = obs_i.obs_right;
    b_t  = obs_i.obs_top;
    b_b  = obs_i.obs_bottom;
    bp_l = obs_i.obs_prev_left;
    bp_r = obs_i.obs_prev_right;
    bp_t = obs_i.obs_prev_top;
    bp_b = obs_i.obs_prev_bottom;
  end

  // strict overlap of the current boxes
  assign overlap = !((a_l >= b_r) || (a_r <= b_l) || (a_t >= b_b) || (a_b <= b_t));

  // horizontal approach side and penetration
  always_comb begin
    hd = '0;
    hs = SideNone;
    if (ap_l >= bp_r) begin
      hd = ext(b_r) - ext(a_l);
      hs = SideRight;
    end else if (ap_r <= bp_l) begin
      hd = ext(b_l) - ext(a_r);
      hs = SideLeft;
    end
  end

  // vertical approach side and penetration
  always_comb begin
    vd = '0;
    vs = SideNone;
    if (ap_t >= bp_b) begin
      vd = ext(b_b) - ext(a_t);
      vs = SideBottom;
    end else if (ap_b <= bp_t) begin
      vd = ext(b_t) - ext(a_b);
      vs = SideTop;
    end
  end

  // a smaller vertical penetration or zero vertical distance picks the horizontal side; ties go vertical
  assign pick   = ((mag(vd) < mag(hd)) || (vd == '0)) ? hs : vs;
  assign side_o = overlap ? pick : SideNone;

endmodule

// ----- src/aabb_contact_side_finder.sv -----
// Contact side finder: streams obstacle boxes, one item per clock unless held up,
// against the moving box held in eight configuration registers, and latches the
// first obstacle whose current box strictly overlaps the mover with a defined
// side of approach. An item is taken into an input register, decided by
// combinational compare logic, and on the item marked last one result (side
// code and latched box, or none and a zero box) is loaded into the output
// register, after which the latch clears. Throughput is one item per cycle
// unless held up; a result is registered in the output register once its last
// item leaves the input register and the output register is free. Only a last
// item waiting on a full, stalled output register holds up the input.
`timescale 1ns / 1ps

module aabb_contact_side_finder import acsf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  coord_t                cfg_data_i,
  // obstacle items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  obs_item_t             in_item_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hit_item_t             out_item_o
);

`include "aabb_contact_side_finder_macros.svh"

  mover_cfg_t mover;
  side_e      calc_side;

  logic       s1_valid_q, s1_valid_d;
  obs_item_t  s1_item_q;
  logic       have_q, have_d;
  side_e      side_q, side_d;
  box_t       box_q, box_d;
  logic       out_valid_q, out_valid_d;
  hit_item_t  out_item_q, out_item_d;

  logic       out_free, adv, adv_last, hit_now;
  box_t       obs_box;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  acsf_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .mover_o    (mover)
  );

  // side decision for the registered item
  acsf_side_calc u_side_calc (
    .mover_i (mover),
    .obs_i   (s1_item_q),
    .side_o  (calc_side)
  );

  // stage advance: items that are not last never need the output register
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = s1_valid_q && (!s1_item_q.last_item || out_free);
  assign adv_last   = adv && s1_item_q.last_item;
  assign in_ready_o = !s1_valid_q || adv;
  assign hit_now    = !have_q && (calc_side != SideNone);

  always_comb begin
    obs_box.left   = s1_item_q.obs_left;
    obs_box.right  = s1_item_q.obs_right;
    obs_box.top    = s1_item_q.obs_top;
    obs_box.bottom = s1_item_q.obs_bottom;
  end

  // input stage
  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  // first-hit latch, cleared at the end of each list
  always_comb begin
    have_d = have_q;
    side_d = side_q;
    box_d  = box_q;
    if (adv) begin
      if (s1_item_q.last_item) begin
        have_d = 1'b0;
        side_d = SideNone;
        box_d  = '0;
      end else if (hit_now) begin
        have_d = 1'b1;
        side_d = calc_side;
        box_d  = obs_box;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      side_q <= SideNone;
      box_q  <= '0;
    end else begin
      have_q <= have_d;
      side_q <= side_d;
      box_q  <= box_d;
    end
  end

  // result register
  always_comb begin
    out_item_d = out_item_q;
    if (have_q) begin
      out_item_d.hit_side   = side_q;
      out_item_d.hit_left   = box_q.left;
      out_item_d.hit_right  = box_q.right;
      out_item_d.hit_top    = box_q.top;
      out_item_d.hit_bottom = box_q.bottom;
    end else if (hit_now) begin
      out_item_d.hit_side   = calc_side;
      out_item_d.hit_left   = obs_box.left;
      out_item_d.hit_right  = obs_box.right;
      out_item_d.hit_top    = obs_box.top;
      out_item_d.hit_bottom = obs_box.bottom;
    end else begin
      out_item_d = '0;
    end
  end

  assign out_valid_d = adv_last ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_last) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a new result only follows a last item leaving the input stage
  `ACSF_ASSERT(a_result_after_last, $rose(out_valid_q) |-> $past(adv_last),
               "result without last item")
  // the latch is empty after every list end
  `ACSF_ASSERT(a_clear_after_last, adv_last |=> !have_q, "latch not cleared after last item")
  // a latched contact always carries a real side
  `ACSF_ASSERT(a_have_side, have_q |-> (side_q != SideNone), "latched contact without side")
  // a miss reports a zero box
  `ACSF_ASSERT(a_none_zero_box,
               (out_valid_q && (out_item_q.hit_side == SideNone)) |->
               ((out_item_q.hit_left == '0) && (out_item_q.hit_right == '0) &&
                (out_item_q.hit_top == '0) && (out_item_q.hit_bottom == '0)),
               "miss with nonzero box")

endmodule

// ----- bench/aabb_contact_side_finder_test.sv -----
// self-checking bench for aabb_contact_side_finder: obstacle lists against mover settings
// depends on acsf_pkg and the aabb_contact_side_finder rtl; predicts each result in-line
`timescale 1ns / 1ps

module aabb_contact_side_finder_test;
  import acsf_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int SettleCycles = 6;
  localparam int LongHold = 400;
  localparam int MaxCfgIdx = (1 << CfgIdxBits) - 1;

  typedef enum int {RxFull, RxHalf, RxSparse, RxComb} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  coord_t                cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  obs_item_t             in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  hit_item_t             out_item_o;

  // obstacles waiting to go out, and contact results still owed by the block
  obs_item_t pending_obs[$];
  hit_item_t expected_hits[$];

  // mirror of the mover registers and of the contact latch
  box_t  mv_cur = '0;
  box_t  mv_prev = '0;
  bit    contact_held = 1'b0;
  side_e held_side = SideNone;
  box_t  held_box = '0;

  // geometry of the current random mover
  int plan_cx, plan_cy, plan_w, plan_h;

  int mismatches = 0;
  int rx_hold_req = 0;
  int idle_cycles = 0;

  aabb_contact_side_finder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  function automatic box_t make_box(int l, int r, int t, int b);
    box_t x;
    x.left   = coord_t'(l);
    x.right  = coord_t'(r);
    x.top    = coord_t'(t);
    x.bottom = coord_t'(b);
    return x;
  endfunction

  function automatic coord_t reg_image(box_t cur, box_t prev, logic [CfgIdxBits-1:0] idx);
    case (idx[RegIdxBits-1:0])
      RegMoverLeft:      return cur.left;
      RegMoverRight:     return cur.right;
      RegMoverTop:       return cur.top;
      RegMoverBottom:    return cur.bottom;
      RegMoverPrevLeft:  return prev.left;
      RegMoverPrevRight: return prev.right;
      RegMoverPrevTop:   return prev.top;
      default:           return prev.bottom;
    endcase
  endfunction

  // update the mover mirror on an accepted register write; high indexes do nothing
  function automatic void store_reg(logic [CfgIdxBits-1:0] idx, coord_t val);
    if (idx < NumRegs) begin
      case (idx[RegIdxBits-1:0])
        RegMoverLeft:      mv_cur.left = val;
        RegMoverRight:     mv_cur.right = val;
        RegMoverTop:       mv_cur.top = val;
        RegMoverBottom:    mv_cur.bottom = val;
        RegMoverPrevLeft:  mv_prev.left = val;
        RegMoverPrevRight: mv_prev.right = val;
        RegMoverPrevTop:   mv_prev.top = val;
        default:           mv_prev.bottom = val;
      endcase
    end
  endfunction

  // contact latch and side choice for one accepted obstacle
  function automatic void predict_contact(obs_item_t o);
    int        hd;
    int        vd;
    side_e     hs;
    side_e     vs;
    side_e     s;
    hit_item_t h;
    hd = 0;
    vd = 0;
    hs = SideNone;
    vs = SideNone;
    s = SideNone;
    if (!contact_held && mv_cur.left < o.obs_right && mv_cur.right > o.obs_left &&
        mv_cur.top < o.obs_bottom && mv_cur.bottom > o.obs_top) begin
      // horizontal approach from the previous frame
      if (mv_prev.left >= o.obs_prev_right) begin
        hd = int'(o.obs_right) - int'(mv_cur.left);
        hs = SideRight;
      end else if (mv_prev.right <= o.obs_prev_left) begin
        hd = int'(o.obs_left) - int'(mv_cur.right);
        hs = SideLeft;
      end
      // vertical approach
      if (mv_prev.top >= o.obs_prev_bottom) begin
        vd = int'(o.obs_bottom) - int'(mv_cur.top);
        vs = SideBottom;
      end else if (mv_prev.bottom <= o.obs_prev_top) begin
        vd = int'(o.obs_top) - int'(mv_cur.bottom);
        vs = SideTop;
      end
      // no vertical distance or a smaller one keeps the horizontal side
      if (vd == 0 || (vd < 0 ? -vd : vd) < (hd < 0 ? -hd : hd)) s = hs;
      else s = vs;
    end
    if (s != SideNone) begin
      contact_held = 1'b1;
      held_side = s;
      held_box = make_box(o.obs_left, o.obs_right, o.obs_top, o.obs_bottom);
    end
    // end of list: report and clear the latch
    if (o.last_item) begin
      h.hit_side   = contact_held ? held_side : SideNone;
      h.hit_left   = contact_held ? held_box.left : '0;
      h.hit_right  = contact_held ? held_box.right : '0;
      h.hit_top    = contact_held ? held_box.top : '0;
      h.hit_bottom = contact_held ? held_box.bottom : '0;
      expected_hits.push_back(h);
      contact_held = 1'b0;
      held_side = SideNone;
      held_box = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endfunction

  function automatic void add_obstacle(box_t cur, box_t prev, bit last);
    pending_obs.push_back({cur.left, cur.right, cur.top, cur.bottom,
                           prev.left, prev.right, prev.top, prev.bottom, last});
  endfunction

  // obstacle placed around the mover, sometimes moving itself
  function automatic void add_near_obstacle(bit last);
    int ow, oh, ox, oy, span_x, span_y, dx, dy;
    ow = $urandom_range(64, 1);
    oh = $urandom_range(64, 1);
    span_x = plan_w + ow + 8;
    span_y = plan_h + oh + 8;
    ox = plan_cx + int'($urandom_range(2 * span_x)) - span_x;
    oy = plan_cy + int'($urandom_range(2 * span_y)) - span_y;
    dx = 0;
    dy = 0;
    if ($urandom_range(3) == 0) begin
      dx = int'($urandom_range(32)) - 16;
      dy = int'($urandom_range(32)) - 16;
    end
    add_obstacle(make_box(ox - ow, ox + ow, oy - oh, oy + oh),
                 make_box(ox - ow + dx, ox + ow + dx, oy - oh + dy, oy + oh + dy), last);
  endfunction

  // fully random item, last flag included
  function automatic void add_noise_obstacle();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    pending_obs.push_back(raw[128:0]);
  endfunction

  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input coord_t val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    store_reg(idx, val);
  endtask

  // all eight mover registers from a random start, optionally after a stray index
  task automatic load_mover(input box_t cur, input box_t prev, input bit stray);
    int start;
    int k;
    logic [CfgIdxBits-1:0] idx;
    start = $urandom_range(NumRegs - 1);
    if (stray) cfg_write(CfgIdxBits'($urandom_range(MaxCfgIdx, NumRegs)), coord_t'($urandom));
    for (k = 0; k < NumRegs; k++) begin
      idx = CfgIdxBits'((start + k) % NumRegs);
      cfg_write(idx, reg_image(cur, prev, idx));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // hold off until every obstacle is in and every result is back;
  // sampled mid-cycle so the driver's updates at the edge have settled
  task automatic drain();
    @(negedge clk_i);
    while (pending_obs.size() != 0 || in_valid_i || expected_hits.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // obstacle driver: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_contact(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_obs.size() != 0) begin
          in_item_i  <= pending_obs.pop_front();
          in_valid_i <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_e rx_mode = RxFull;
  always @(posedge clk_i) begin : result_monitor
    hit_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result item: side %0d", out_item_o.hit_side);
          mismatches++;
        end else begin
          want = expected_hits.pop_front();
          check_field("hit_side", want.hit_side, out_item_o.hit_side);
          check_field("hit_left", want.hit_left, out_item_o.hit_left);
          check_field("hit_right", want.hit_right, out_item_o.hit_right);
          check_field("hit_top", want.hit_top, out_item_o.hit_top);
          check_field("hit_bottom", want.hit_bottom, out_item_o.hit_bottom);
        end
      end
      if (rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(3));
          mode_left = $urandom_range(96, 16);
        end
        mode_left--;
        case (rx_mode)
          RxFull:   out_ready_i <= 1'b1;
          RxHalf:   out_ready_i <= $urandom_range(1);
          RxSparse: out_ready_i <= ($urandom_range(3) == 0);
          default:  out_ready_i <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("aabb_contact_side_finder verification failed");
          $finish;
        end
      end
    end
  end

  // stimulus
  initial begin
    int phase;
    int k;
    int j;
    int len;
    int n_lists;
    int vx;
    int vy;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // mover sliding down and right into a field of obstacles
    load_mover(make_box(0, 10, 0, 10), make_box(-20, -10, -20, -10), 1'b0);
    // touching edge is no overlap
    add_obstacle(make_box(10, 20, 0, 10), make_box(10, 20, 0, 10), 1'b0);
    // overlap but previous boxes overlap too: no side, zero box
    add_obstacle(make_box(5, 15, 5, 15), make_box(-25, -5, -25, -5), 1'b1);
    // equal distances go vertical
    add_obstacle(make_box(5, 30, 5, 30), make_box(5, 30, 5, 30), 1'b1);
    // no vertical side picks the horizontal one
    add_obstacle(make_box(5, 30, -5, 15), make_box(5, 30, -25, 25), 1'b1);
    // no horizontal side
    add_obstacle(make_box(-5, 15, 5, 30), make_box(-25, 25, 5, 30), 1'b1);
    // right and bottom approach
    add_obstacle(make_box(-20, 5, -20, 5), make_box(-60, -40, -60, -40), 1'b1);
    add_obstacle(make_box(-20, 5, -30, 20), make_box(-60, -40, -60, 40), 1'b1);
    // smaller vertical distance keeps the horizontal side
    add_obstacle(make_box(-30, 9, 8, 30), make_box(-70, -50, 8, 30), 1'b1);
    // later hits in the same list are ignored
    add_obstacle(make_box(20, 30, 20, 30), make_box(20, 30, 20, 30), 1'b0);
    add_obstacle(make_box(5, 30, 5, 30), make_box(5, 30, 5, 30), 1'b0);
    add_obstacle(make_box(-20, 5, -20, 5), make_box(-60, -40, -60, -40), 1'b0);
    add_obstacle(make_box(20, 30, 20, 30), make_box(20, 30, 20, 30), 1'b1);
    // full-range obstacles
    add_obstacle(make_box(-32768, 32767, -32768, 32767),
                 make_box(-32768, 32767, -32768, 32767), 1'b0);
    add_obstacle(make_box(-32768, 32767, -32768, 32767),
                 make_box(32767, 32767, 32767, 32767), 1'b1);
    add_obstacle(make_box(0, 10, 10, 20), make_box(0, 10, 10, 20), 1'b1);
    drain();

    // mover at the coordinate extremes
    load_mover(make_box(-32768, 32767, -32768, 32767),
               make_box(32767, -32768, 32767, -32768), 1'b1);
    add_obstacle(make_box(0, 1, 0, 1), make_box(0, 1, 0, 1), 1'b1);
    add_obstacle(make_box(32766, 32767, -32768, -32767),
                 make_box(-32768, 32767, -32768, 32767), 1'b1);
    add_obstacle(make_box(-32768, -32767, 32766, 32767), make_box(-1, 0, -1, 0), 1'b1);
    drain();

    // random movers with obstacle lists around them
    for (phase = 0; phase < 12; phase++) begin
      plan_w = $urandom_range(64);
      plan_h = $urandom_range(64);
      plan_cx = int'($urandom_range(60000)) - 30000;
      plan_cy = int'($urandom_range(60000)) - 30000;
      if (phase == 10) begin
        plan_cx = 32700;
        plan_cy = -32700;
      end
      vx = int'($urandom_range(200)) - 100;
      vy = int'($urandom_range(200)) - 100;
      load_mover(make_box(plan_cx - plan_w, plan_cx + plan_w, plan_cy - plan_h, plan_cy + plan_h),
                 make_box(plan_cx - plan_w - vx, plan_cx + plan_w - vx,
                          plan_cy - plan_h - vy, plan_cy + plan_h - vy),
                 $urandom_range(1));
      // long receiver stall with short lists so the block backs up
      if (phase == 4) rx_hold_req = LongHold;
      n_lists = (phase == 4) ? 40 : 24;
      for (k = 0; k < n_lists; k++) begin
        if (phase == 7 && k == n_lists / 2) drain();
        if ($urandom_range(4) == 0) begin
          add_noise_obstacle();
        end else begin
          len = (phase == 4) ? $urandom_range(2, 1) : $urandom_range(6, 1);
          for (j = 0; j < len; j++) add_near_obstacle(j == len - 1);
        end
      end
      drain();
    end

    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("aabb_contact_side_finder verification clean");
    end else begin
      $display("aabb_contact_side_finder verification failed");
    end
    $finish;
  end

endmodule
